>>> rtl/core/laplacian_edge_3x3_rgb_assert.svh
// assertion macros shared by the laplacian edge filter rtl
// no dependencies; included by the modules that check their own logic
`ifndef LAPLACIAN_EDGE_3X3_RGB_ASSERT_SVH
`define LAPLACIAN_EDGE_3X3_RGB_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define LAP3_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define LAP3_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/lap3_pkg.sv
// shared types and constants of the 3x3 laplacian edge filter
// no dependencies; imported by every module of the block
`default_nettype none

package lap3_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int WIDTH_RST     = 640;
	localparam int HEIGHT_RST    = 480;
	localparam int QUEUE_DEPTH   = 2;
	localparam int Q_PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam logic [7:0] CHAN_MAX = 8'hFF;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// one classified item: 3x3 neighborhood, nb[4] is the center, nb[8] the new pixel
	typedef struct packed {
		logic            border;
		logic            interior;
		logic [9:0]      col;
		logic [11:0]     row;
		pixel_t [8:0]    nb;
	} entry_t;

	typedef struct packed {
		logic [9:0]  col;
		logic [11:0] row;
		pixel_t      px;
		logic        last;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/core/laplacian_edge_3x3_rgb.sv
// channel   | dir | handshake                   | payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: red_in, green_in, blue_in
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: pixel_column, pixel_row, rgb; tlast
// cfg       | in  | cfg_wr_en (no wait)         | cfg_index, cfg_data
//
// sustained rate is one item per cycle while m_axis_tready stays high and each item yields at
// most one result; an item that yields two results holds the single output register for both,
// so the result channel sets the rate. the first result of an item passes the front-end stage 1
// register, the queue, the back-end stage register and the output register before it is valid.
// arst_n clears counters, handshake state and the frame size (640 x 480); line stores are not
// cleared and need no clearing pass. a two-entry queue lets the front end keep accepting
// while the output side is stalled.
//
// top level of the 3x3 laplacian edge filter for raster-order rgb pixels
// depends on lap3_pkg, lap3_front, lap3_queue, lap3_back
`default_nettype none

module laplacian_edge_3x3_rgb import lap3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration writes: index 0 image_width, index 1 image_height
	input  wire logic        cfg_wr_en,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [11:0] cfg_data,
	// input pixels
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // red_in, green_in, blue_in
	// results
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [47:0] m_axis_tdata,   // pixel_column, pixel_row, red_out, green_out, blue_out, pad
	output      logic        m_axis_tlast    // last_of_run
);

	pixel_t  in_pixel;
	entry_t  push_entry, head_entry;
	logic    q_push, q_ready, q_valid, q_pop;
	result_t out_item;

	// unpack the input item, red in the low byte
	always_comb begin
		in_pixel.red   = s_axis_tdata[7:0];
		in_pixel.green = s_axis_tdata[15:8];
		in_pixel.blue  = s_axis_tdata[23:16];
	end

	// front end: counters, line stores, window, border / interior flags
	lap3_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pixel  (in_pixel),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	// decoupling queue
	lap3_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_ready (q_ready),
		.push_entry (push_entry),
		.head_valid (q_valid),
		.pop        (q_pop),
		.head_entry (head_entry)
	);

	// back end: laplacian and result ordering, border result before interior result
	lap3_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_entry   (head_entry),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	// pack the result item, column in the low bits, padded to six bytes
	assign m_axis_tdata = {2'b00, out_item.px.blue, out_item.px.green, out_item.px.red,
	                       out_item.row, out_item.col};
	assign m_axis_tlast = out_item.last;

endmodule

`default_nettype wire

>>> rtl/core/lap3_front.sv
// front end: raster counters, two line stores, 3x3 window and item classification
// depends on lap3_pkg
`default_nettype none

module lap3_front import lap3_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_wr_en,
	input  wire logic [0:0]   cfg_index,
	input  wire logic [11:0]  cfg_data,
	input  wire logic         in_valid,
	output      logic         in_ready,
	input  wire pixel_t       in_pixel,
	input  wire logic         q_ready,
	output      logic         q_push,
	output      entry_t       q_entry
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

	logic [COL_W-1:0] col_q, w_last_q, w_last_nxt;
	logic [11:0]      row_q, h_last_q, h_last_nxt;
	logic [12:0]      w_val, w_eff;
	logic [11:0]      h_eff;

	logic             in_acc, s1_go, keep_s1;
	logic             border_s0, interior_s0;

	logic             v_s1_q;
	logic             border_s1, interior_s1;
	logic [COL_W-1:0] col_s1;
	logic [11:0]      row_s1;
	pixel_t           px_s1, top_s1, mid_s1;
	pixel_t           win_q [6];

	pixel_t           above_mem     [MAX_WIDTH];
	pixel_t           two_above_mem [MAX_WIDTH];

	// saturate register writes to the supported frame size
	always_comb begin
		w_val      = {2'b00, cfg_data[10:0]};
		w_eff      = (w_val < 13'd3) ? 13'd3 :
		             (w_val > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : w_val;
		w_last_nxt = COL_W'(w_eff - 13'd1);
		h_eff      = (cfg_data < 12'd3) ? 12'd3 : cfg_data;
		h_last_nxt = h_eff - 12'd1;
	end

	always_comb begin
		border_s0   = (col_q == '0) || (row_q == '0) || (col_q == w_last_q) ||
		              (row_q == h_last_q);
		interior_s0 = (col_q >= COL_W'(2)) && (row_q >= 12'd2);
	end

	assign keep_s1  = border_s1 || interior_s1;
	assign s1_go    = v_s1_q && (q_ready || !keep_s1);
	assign q_push   = v_s1_q && keep_s1 && q_ready;
	assign in_ready = !v_s1_q || s1_go;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			w_last_q <= COL_W'(W_RST - 1);
			h_last_q <= 12'(HEIGHT_RST - 1);
		end else if (cfg_wr_en) begin
			// any write restarts the frame
			col_q <= '0;
			row_q <= '0;
			unique case (reg_idx_t'(cfg_index))
				REG_IMAGE_WIDTH:  w_last_q <= w_last_nxt;
				REG_IMAGE_HEIGHT: h_last_q <= h_last_nxt;
				default:          w_last_q <= w_last_q;
			endcase
		end else if (in_acc) begin
			if (col_q == w_last_q) begin
				col_q <= '0;
				row_q <= (row_q == h_last_q) ? '0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (in_acc) begin
			v_s1_q <= 1'b1;
		end else if (s1_go) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			border_s1   <= border_s0;
			interior_s1 <= interior_s0;
			col_s1      <= col_q;
			row_s1      <= row_q;
			px_s1       <= in_pixel;
		end
	end

	// line stores: registered read on accept, write back as the item leaves stage 1
	always_ff @(posedge clk) begin
		if (in_acc) begin
			top_s1 <= two_above_mem[col_q];
			mid_s1 <= above_mem[col_q];
		end
		if (s1_go) begin
			two_above_mem[col_s1] <= mid_s1;
			above_mem[col_s1]     <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_s1;
			win_q[4] <= mid_s1;
			win_q[5] <= px_s1;
		end
	end

	always_comb begin
		q_entry.border   = border_s1;
		q_entry.interior = interior_s1;
		q_entry.col      = 10'(col_s1);
		q_entry.row      = row_s1;
		q_entry.nb[0]    = win_q[0];
		q_entry.nb[1]    = win_q[3];
		q_entry.nb[2]    = top_s1;
		q_entry.nb[3]    = win_q[1];
		q_entry.nb[4]    = win_q[4];
		q_entry.nb[5]    = mid_s1;
		q_entry.nb[6]    = win_q[2];
		q_entry.nb[7]    = win_q[5];
		q_entry.nb[8]    = px_s1;
	end

endmodule

`default_nettype wire

>>> rtl/core/lap3_queue.sv
// short fifo of classified items between front and back end
// depends on lap3_pkg and laplacian_edge_3x3_rgb_assert.svh
`default_nettype none

`include "laplacian_edge_3x3_rgb_assert.svh"

module lap3_queue import lap3_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	output      logic   push_ready,
	input  wire entry_t push_entry,
	output      logic   head_valid,
	input  wire logic   pop,
	output      entry_t head_entry
);

	entry_t             slot_q [QUEUE_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign push_ready = (cnt_q != Q_CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`LAP3_ASSERT_NOW(a_no_overflow, clk, arst_n, push, push_ready, "queue push while full")
	`LAP3_ASSERT_NOW(a_no_underflow, clk, arst_n, pop, head_valid, "queue pop while empty")
	`LAP3_ASSERT_NEXT(a_cnt_up, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow")

endmodule

`default_nettype wire

>>> rtl/core/lap3_back.sv
// back end: neighbor sums, laplacian clamp and result sequencing into the output register
// depends on lap3_pkg and laplacian_edge_3x3_rgb_assert.svh
`default_nettype none

`include "laplacian_edge_3x3_rgb_assert.svh"

module lap3_back import lap3_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_valid,
	input  wire entry_t  q_entry,
	output      logic    q_pop,
	output      logic    out_valid,
	input  wire logic    out_ready,
	output      result_t out_item
);

	function automatic logic [7:0] lap_clamp(input logic [7:0] ctr, input logic [10:0] nsum);
		logic [11:0] d;
		d = {1'b0, ctr, 3'b000} - {1'b0, nsum};
		if (d[11]) begin
			lap_clamp = '0;
		end else if (d[10:8] != '0) begin
			lap_clamp = CHAN_MAX;
		end else begin
			lap_clamp = d[7:0];
		end
	endfunction

	logic [10:0] sum_r, sum_g, sum_b;

	logic        b1_v_q;
	logic        border_s1, interior_s1;
	logic [9:0]  col_s1;
	logic [11:0] row_s1;
	pixel_t      px_s1, ctr_s1;
	logic [10:0] sum_r_s1, sum_g_s1, sum_b_s1;

	logic        phase_q, out_valid_q;
	result_t     out_item_q;

	logic        out_load, emit_border, b1_done, b1_load;
	result_t     res_nxt;

	// sum of the eight neighbors per channel
	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != 4) begin
				sum_r = sum_r + 11'(q_entry.nb[i].red);
				sum_g = sum_g + 11'(q_entry.nb[i].green);
				sum_b = sum_b + 11'(q_entry.nb[i].blue);
			end
		end
	end

	assign out_load    = b1_v_q && (!out_valid_q || out_ready);
	assign emit_border = border_s1 && !phase_q;
	assign b1_done     = out_load && (!emit_border || !interior_s1);
	assign b1_load     = q_valid && (!b1_v_q || b1_done);
	assign q_pop       = b1_load;

	always_comb begin
		if (emit_border) begin
			res_nxt.col  = col_s1;
			res_nxt.row  = row_s1;
			res_nxt.px   = px_s1;
			res_nxt.last = !interior_s1;
		end else begin
			res_nxt.col      = col_s1 - 10'd1;
			res_nxt.row      = row_s1 - 12'd1;
			res_nxt.px.red   = lap_clamp(ctr_s1.red, sum_r_s1);
			res_nxt.px.green = lap_clamp(ctr_s1.green, sum_g_s1);
			res_nxt.px.blue  = lap_clamp(ctr_s1.blue, sum_b_s1);
			res_nxt.last     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_q      <= 1'b0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (b1_load) begin
				b1_v_q <= 1'b1;
			end else if (b1_done) begin
				b1_v_q <= 1'b0;
			end
			if (out_load) begin
				phase_q     <= emit_border && interior_s1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (b1_load) begin
			border_s1   <= q_entry.border;
			interior_s1 <= q_entry.interior;
			col_s1      <= q_entry.col;
			row_s1      <= q_entry.row;
			px_s1       <= q_entry.nb[8];
			ctr_s1      <= q_entry.nb[4];
			sum_r_s1    <= sum_r;
			sum_g_s1    <= sum_g;
			sum_b_s1    <= sum_b;
		end
		if (out_load) begin
			out_item_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`LAP3_ASSERT_NOW(a_phase_both, clk, arst_n, phase_q, b1_v_q && border_s1 && interior_s1, "second result without a pending interior item")
	`LAP3_ASSERT_NOW(a_b1_has_result, clk, arst_n, b1_v_q, border_s1 || interior_s1, "item without results reached the back end")
	`LAP3_ASSERT_NEXT(a_phase_follows, clk, arst_n, out_load && emit_border && interior_s1, phase_q, "interior result lost after border result")

endmodule

`default_nettype wire

>>> test/tb_laplacian_edge_3x3_rgb.sv
// self-checking testbench for the 3x3 laplacian edge filter on raster-order rgb pixels
// depends on lap3_pkg and laplacian_edge_3x3_rgb
// a class predicts every result and checks it in order
`timescale 1ns / 1ps

module tb_laplacian_edge_3x3_rgb import lap3_pkg::*;;

	localparam int DRAIN_CYCLES = 16;    // slack for the pipeline to empty after the last expected result
	localparam int STALL_LIMIT  = 2000;  // cycles with nothing accepted before giving up
	localparam int RANDOM_ITEMS = 1950;

	// predicts the filter output and checks results against it in arrival order
	class edge_scoreboard;
		logic [10:0] width_reg;
		logic [11:0] height_reg;
		pixel_t      line_above [MAX_WIDTH_DEF];
		pixel_t      line_two_above [MAX_WIDTH_DEF];
		pixel_t      window [6];
		int          col;
		int          row;
		result_t     expected_pixels [$];
		int          errors;

		function new();
			width_reg = 11'(WIDTH_RST);
			height_reg = 12'(HEIGHT_RST);
			foreach (line_above[i]) begin
				line_above[i] = '0;
				line_two_above[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			col = 0;
			row = 0;
			errors = 0;
		endfunction

		// one line per mismatch, printing capped to keep the log short
		task report(input string msg);
			errors++;
			if (errors <= 40) $display("mismatch: %s", msg);
		endtask

		// any register write restarts the frame
		function void write_reg(input reg_idx_t idx, input logic [11:0] value);
			if (idx == REG_IMAGE_WIDTH) width_reg = value[10:0];
			else height_reg = value;
			col = 0;
			row = 0;
		endfunction

		function logic [7:0] clamp_channel(input int v);
			if (v < 0) return 8'h00;
			if (v > 255) return CHAN_MAX;
			return v[7:0];
		endfunction

		// 8 * center minus the eight neighbors, per channel; nb[4] is the center
		function pixel_t laplace_pixel(input pixel_t [8:0] nb);
			int     r;
			int     g;
			int     b;
			pixel_t res;
			r = 0;
			g = 0;
			b = 0;
			for (int i = 0; i < 9; i++) begin
				if (i == 4) begin
					r += 8 * int'(nb[i].red);
					g += 8 * int'(nb[i].green);
					b += 8 * int'(nb[i].blue);
				end else begin
					r -= int'(nb[i].red);
					g -= int'(nb[i].green);
					b -= int'(nb[i].blue);
				end
			end
			res.red = clamp_channel(r);
			res.green = clamp_channel(g);
			res.blue = clamp_channel(b);
			return res;
		endfunction

		// one accepted pixel: queue the border pass-through and the interior result it completes
		function void note_pixel(input logic [23:0] d);
			int           w;
			int           h;
			pixel_t       px;
			pixel_t       top;
			pixel_t       mid;
			pixel_t [8:0] nb;
			result_t      edge_r;
			result_t      inner_r;
			logic         is_border;
			logic         is_inner;
			w = width_reg;
			if (w < 3) w = 3;
			if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
			h = height_reg;
			if (h < 3) h = 3;
			px.red = d[7:0];
			px.green = d[15:8];
			px.blue = d[23:16];
			top = line_two_above[col];
			mid = line_above[col];
			is_border = (col == 0) || (row == 0) || (col >= w - 1) || (row >= h - 1);
			is_inner = (col >= 2) && (row >= 2);
			if (is_border) begin
				edge_r.col = col[9:0];
				edge_r.row = row[11:0];
				edge_r.px = px;
				edge_r.last = !is_inner;
				expected_pixels.push_back(edge_r);
			end
			if (is_inner) begin
				nb[0] = window[0];
				nb[1] = window[3];
				nb[2] = top;
				nb[3] = window[1];
				nb[4] = window[4];
				nb[5] = mid;
				nb[6] = window[2];
				nb[7] = window[5];
				nb[8] = px;
				inner_r.col = 10'(col - 1);
				inner_r.row = 12'(row - 1);
				inner_r.px = laplace_pixel(nb);
				inner_r.last = 1'b1;
				expected_pixels.push_back(inner_r);
			end
			window[0] = window[3];
			window[1] = window[4];
			window[2] = window[5];
			window[3] = top;
			window[4] = mid;
			window[5] = px;
			line_two_above[col] = mid;
			line_above[col] = px;
			if (col + 1 >= w) begin
				col = 0;
				row = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col = col + 1;
			end
		endfunction

		task check_result(input logic [47:0] d, input logic last);
			result_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("result at (%0d,%0d) with nothing expected",
					d[9:0], d[21:10]));
				return;
			end
			want = expected_pixels.pop_front();
			if (d[9:0] !== want.col || d[21:10] !== want.row || d[29:22] !== want.px.red ||
					d[37:30] !== want.px.green || d[45:38] !== want.px.blue ||
					d[47:46] !== 2'b00 || last !== want.last) begin
				report($sformatf({"want (%0d,%0d) rgb %h %h %h last %b, ",
					"got (%0d,%0d) rgb %h %h %h last %b pad %b"},
					want.col, want.row, want.px.red, want.px.green, want.px.blue, want.last,
					d[9:0], d[21:10], d[29:22], d[37:30], d[45:38], last, d[47:46]));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [0:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // red_in, green_in, blue_in
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // pixel_column, pixel_row, red_out, green_out, blue_out, pad
	logic        m_axis_tlast;        // last_of_run

	edge_scoreboard board;
	int             idle_cycles = 0;
	int             burst_left = 0;
	int             ready_mode = 0;
	int             ready_hold = 0;
	int             ready_tick = 0;

	laplacian_edge_3x3_rgb dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sample every handshake at the edge, feed the scoreboard, and watch for a hang
	always @(posedge clk) begin : monitor
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (cfg_wr_en) begin
				board.write_reg(reg_idx_t'(cfg_index), cfg_data);
				moved = 1'b1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				board.note_pixel(s_axis_tdata);
				moved = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_result(m_axis_tdata, m_axis_tlast);
				moved = 1'b1;
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver backpressure: a mode held for a random stretch, from always ready to mostly stalled
	always @(posedge clk) begin
		if (ready_hold == 0) begin
			ready_mode = $urandom_range(0, 4);
			ready_hold = $urandom_range(20, 300);
		end else begin
			ready_hold--;
		end
		ready_tick++;
		case (ready_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= 1'($urandom_range(0, 1));
			2: m_axis_tready <= ($urandom_range(0, 3) == 0);
			3: m_axis_tready <= ((ready_tick % 8) < 4);
			default: m_axis_tready <= ($urandom_range(0, 9) != 0);
		endcase
	end

	function automatic logic [23:0] pack_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {b, g, r};
	endfunction

	// mix of uniform noise, saturated channels and flat areas around a base level
	function automatic logic [23:0] random_pixel(input logic [7:0] base);
		logic [23:0] v;
		int          mode;
		for (int k = 0; k < 3; k++) begin
			mode = $urandom_range(0, 9);
			if (mode < 5) v[8*k +: 8] = 8'($urandom);
			else if (mode < 7) v[8*k +: 8] = {8{1'($urandom_range(0, 1))}};
			else v[8*k +: 8] = base + 8'($urandom_range(0, 15));
		end
		return v;
	endfunction

	// one pixel item; bursts of random length with random gaps between them
	task automatic send_pixel(input logic [23:0] d);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if ($urandom_range(0, 30) == 0) gap = $urandom_range(20, 60);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 48);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		burst_left--;
	endtask

	// stop sending, wait for every expected result, then let the pipeline empty
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (board.expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input reg_idx_t idx, input logic [11:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int          sent;
		int          phase;
		int          n;
		int          ew;
		int          eh;
		logic [11:0] wdata;
		logic [11:0] hdata;
		logic [7:0]  base;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 640 x 480: first row pixels, all border, channel extremes
		send_pixel(pack_pixel(8'h00, 8'h00, 8'h00));
		send_pixel(pack_pixel(8'hFF, 8'hFF, 8'hFF));
		send_pixel(pack_pixel(8'hAA, 8'h55, 8'hAA));
		send_pixel(pack_pixel(8'h55, 8'hAA, 8'h55));
		settle();

		// smallest frame: red clamps high, green clamps low, blue stays in range
		write_cfg(REG_IMAGE_WIDTH, 12'd3);
		write_cfg(REG_IMAGE_HEIGHT, 12'd3);
		for (int i = 0; i < 9; i++)
			send_pixel(i == 4 ? pack_pixel(8'hFF, 8'h00, 8'd50) :
				pack_pixel(8'h00, 8'hFF, 8'd40));
		// row wraps back to zero into the next frame, which is cut short
		for (int i = 0; i < 3; i++) send_pixel(random_pixel(8'h40));
		settle();
		// height below range saturates; the write restarts the frame mid-way
		write_cfg(REG_IMAGE_HEIGHT, 12'd2);
		for (int i = 0; i < 9; i++) send_pixel(random_pixel(8'h80));

		sent = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			base = 8'($urandom);
			if (phase == 2) begin
				// widest row, reached also through values above the range
				wdata = 12'($urandom_range(1024, 2047));
				if ($urandom_range(0, 1) == 1) wdata[11] = 1'b1;
				hdata = 12'd3;
				n = 1024 + $urandom_range(2, 10);
			end else if (phase == 5) begin
				// tallest frame, only its first rows
				wdata = 12'd3;
				hdata = 12'd4095;
				n = 12 + $urandom_range(0, 5);
			end else begin
				wdata = 12'($urandom_range(3, 12));
				hdata = 12'($urandom_range(3, 7));
				if ($urandom_range(0, 7) == 0) wdata = 12'($urandom_range(0, 2));
				if ($urandom_range(0, 7) == 0) hdata = 12'($urandom_range(0, 2));
				// bit 11 is not part of the width register
				if ($urandom_range(0, 4) == 0) wdata[11] = 1'b1;
				ew = (wdata[10:0] < 3) ? 3 : wdata[10:0];
				eh = (hdata < 3) ? 3 : hdata;
				n = ew * eh * $urandom_range(1, 2) + $urandom_range(0, ew * eh);
			end
			// sometimes a throwaway value first, so the later write must win
			if ($urandom_range(0, 3) == 0)
				write_cfg($urandom_range(0, 1) ? REG_IMAGE_WIDTH : REG_IMAGE_HEIGHT,
					12'($urandom));
			if ($urandom_range(0, 1) == 1) begin
				write_cfg(REG_IMAGE_WIDTH, wdata);
				write_cfg(REG_IMAGE_HEIGHT, hdata);
			end else begin
				write_cfg(REG_IMAGE_HEIGHT, hdata);
				write_cfg(REG_IMAGE_WIDTH, wdata);
			end
			for (int i = 0; i < n; i++) send_pixel(random_pixel(base));
			sent += n;
			phase++;
		end
		settle();

		if (board.errors == 0 && board.expected_pixels.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/lap3_pkg.sv
rtl/core/lap3_front.sv
rtl/core/lap3_queue.sv
rtl/core/lap3_back.sv
rtl/core/laplacian_edge_3x3_rgb.sv
test/tb_laplacian_edge_3x3_rgb.sv
